/* rtl/core/bdfe_pkg.sv */
package bdfe_pkg;

   localparam int BEAM_COUNT = 64;
   localparam int BEAM_W = $clog2(BEAM_COUNT);
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [16:0] Q_ONE = 17'd32768;
   localparam logic [15:0] Q_ONE16 = 16'd32768;
   localparam logic [32:0] Q_HALF = 33'd16384;

   localparam logic [BEAM_W-1:0] CENTER_FIRST = BEAM_W'(22);
   localparam logic [BEAM_W-1:0] CENTER_END = BEAM_W'(42);
   localparam logic [BEAM_W-1:0] EDGE_SPAN = BEAM_W'(12);
   localparam logic [BEAM_W-1:0] EDGE_START = BEAM_W'(BEAM_COUNT - 12);
   localparam logic [BEAM_W-1:0] LAST_BEAM = BEAM_W'(BEAM_COUNT - 1);

   localparam logic [7:0] SUMMARY_BASE = 8'd128;
   localparam logic [3:0] SUMMARY_LAST = 4'd15;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSING_FULL_SPEED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DANGER_FLOOR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_LEVEL_LOW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_LEVEL_MID = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_LEVEL_HIGH = 3'd5;

   typedef struct packed {
      logic [15:0] range_limit;
      logic [14:0] closing_full_speed;
      logic [15:0] danger_floor;
      logic [15:0] count_level_low;
      logic [15:0] count_level_mid;
      logic [15:0] count_level_high;
   } csr_type;

   // One classified beam waiting for the back end.
   typedef struct packed {
      logic [BEAM_W-1:0] beam;
      logic              p_zero;
      logic [15:0]       p_num;
      logic [15:0]       p_den;
      logic              c_zero;
      logic              c_full;
      logic [15:0]       c_num;
      logic [15:0]       c_den;
   } item_type;

   function automatic logic [15:0] beam_gain(input logic [BEAM_W-1:0] beam);
      logic [15:0] g;
      case (beam)
         6'd0: g = 16'd568;     6'd1: g = 16'd731;     6'd2: g = 16'd935;
         6'd3: g = 16'd1185;    6'd4: g = 16'd1490;    6'd5: g = 16'd1857;
         6'd6: g = 16'd2297;    6'd7: g = 16'd2818;    6'd8: g = 16'd3429;
         6'd9: g = 16'd4138;    6'd10: g = 16'd4954;   6'd11: g = 16'd5881;
         6'd12: g = 16'd6926;   6'd13: g = 16'd8090;   6'd14: g = 16'd9372;
         6'd15: g = 16'd10769;  6'd16: g = 16'd12274;  6'd17: g = 16'd13875;
         6'd18: g = 16'd15558;  6'd19: g = 16'd17302;  6'd20: g = 16'd19085;
         6'd21: g = 16'd20881;  6'd22: g = 16'd22660;  6'd23: g = 16'd24389;
         6'd24: g = 16'd26038;  6'd25: g = 16'd27571;  6'd26: g = 16'd28957;
         6'd27: g = 16'd30165;  6'd28: g = 16'd31168;  6'd29: g = 16'd31942;
         6'd30: g = 16'd32468;  6'd31: g = 16'd32735;  6'd32: g = 16'd32735;
         6'd33: g = 16'd32468;  6'd34: g = 16'd31942;  6'd35: g = 16'd31168;
         6'd36: g = 16'd30165;  6'd37: g = 16'd28957;  6'd38: g = 16'd27571;
         6'd39: g = 16'd26038;  6'd40: g = 16'd24389;  6'd41: g = 16'd22660;
         6'd42: g = 16'd20881;  6'd43: g = 16'd19085;  6'd44: g = 16'd17302;
         6'd45: g = 16'd15558;  6'd46: g = 16'd13875;  6'd47: g = 16'd12274;
         6'd48: g = 16'd10769;  6'd49: g = 16'd9372;   6'd50: g = 16'd8090;
         6'd51: g = 16'd6926;   6'd52: g = 16'd5881;   6'd53: g = 16'd4954;
         6'd54: g = 16'd4138;   6'd55: g = 16'd3429;   6'd56: g = 16'd2818;
         6'd57: g = 16'd2297;   6'd58: g = 16'd1857;   6'd59: g = 16'd1490;
         6'd60: g = 16'd1185;   6'd61: g = 16'd935;    6'd62: g = 16'd731;
         6'd63: g = 16'd568;
         default: g = 16'd0;
      endcase
      return g;
   endfunction

endpackage

/* rtl/core/bdfe_if.sv */
interface bdfe_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] distance;
   logic signed [15:0] velocity;

   modport source (output valid, output distance, output velocity, input ready);
   modport sink (input valid, input distance, input velocity, output ready);
endinterface

interface bdfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] feature_index;
   logic [15:0] feature_value;
   logic [6:0] feature_code;
   logic       frame_done;

   modport source (output valid, output feature_index, output feature_value,
                   output feature_code, output frame_done, input ready);
   modport sink (input valid, input feature_index, input feature_value,
                 input feature_code, input frame_done, output ready);
endinterface

/* rtl/core/beam_danger_feature_encoder_unit.sv */
// Beam danger feature encoder.
// req_bus carries one beam word (distance, velocity) per handshake; the beams of
// a frame arrive in order, 64 per frame. rsp_bus returns per beam a danger word
// (index 0..63) and then a proximity word (index 64..127); after the last beam of
// a frame sixteen summary words follow (index 128..143), frame_done marking the last.
// csr_write_enable writes csr_write_data into the register csr_index selects;
// the user must write registers only while the block is idle; it does not check this.
// Per beam the back end takes the word from the queue, waits for the two radix-2
// dividers that run side by side, runs four multiply and rounding steps and emits
// the danger and proximity words; a frame end adds the summary steps.
// A small queue lets the front accept beams while the back end still works.
// When the receiver stalls, the output register holds its word and the back end
// waits; the queue fills and req_bus.ready drops.
// Reset restores the register defaults, clears the queue, the beam counter and all
// frame accumulators; no result is pending after reset.
module beam_danger_feature_encoder_unit
   import bdfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   bdfe_req_if.sink               req_bus,
   bdfe_rsp_if.source             rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   csr_type  csr_ff, csr_in;
   item_type push_item, head_item;
   logic     push, pop, queue_full, queue_empty;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RANGE_LIMIT: csr_in.range_limit = csr_write_data;
            CSR_CLOSING_FULL_SPEED: csr_in.closing_full_speed = csr_write_data[14:0];
            CSR_DANGER_FLOOR: csr_in.danger_floor = csr_write_data;
            CSR_COUNT_LEVEL_LOW: csr_in.count_level_low = csr_write_data;
            CSR_COUNT_LEVEL_MID: csr_in.count_level_mid = csr_write_data;
            CSR_COUNT_LEVEL_HIGH: csr_in.count_level_high = csr_write_data;
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.range_limit <= 16'd6144;
         csr_ff.closing_full_speed <= 15'd6144;
         csr_ff.danger_floor <= 16'd8192;
         csr_ff.count_level_low <= 16'd1638;
         csr_ff.count_level_mid <= 16'd3277;
         csr_ff.count_level_high <= 16'd6554;
      end else begin
         csr_ff <= csr_in;
      end
   end

   bdfe_front u_front (
      .clock(clock), .reset(reset), .req_bus(req_bus), .csr(csr_ff),
      .queue_full(queue_full), .push(push), .item(push_item)
   );

   bdfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .head_item(head_item), .full(queue_full), .empty(queue_empty)
   );

   bdfe_back u_back (
      .clock(clock), .reset(reset), .csr(csr_ff), .queue_empty(queue_empty),
      .head_item(head_item), .pop(pop), .rsp_bus(rsp_bus)
   );

endmodule

/* rtl/core/bdfe_front.sv */
module bdfe_front
   import bdfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   bdfe_req_if.sink      req_bus,
   input  csr_type       csr,
   input  logic          queue_full,
   output logic          push,
   output item_type      item
);

   logic [BEAM_W-1:0] beam_ff, beam_in;
   logic [15:0] vraw;
   logic [15:0] approach;
   logic [15:0] full_speed;

   assign vraw = req_bus.velocity;
   assign approach = vraw[15] ? (16'd0 - vraw) : 16'd0;
   assign full_speed = {1'b0, csr.closing_full_speed};

   assign req_bus.ready = !queue_full;
   assign push = req_bus.valid && !queue_full;

   always_comb begin
      item.beam = beam_ff;
      item.p_zero = req_bus.distance >= csr.range_limit;
      item.p_num = csr.range_limit - req_bus.distance;
      item.p_den = csr.range_limit;
      item.c_zero = approach == 16'd0;
      item.c_full = approach >= full_speed;
      item.c_num = approach;
      item.c_den = full_speed;
   end

   // The beam number wraps with the frame; the last beam starts the next frame at zero.
   assign beam_in = push ? beam_ff + 1'b1 : beam_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_ff <= '0;
      end else begin
         beam_ff <= beam_in;
      end
   end

endmodule

/* rtl/core/bdfe_queue.sv */
module bdfe_queue
   import bdfe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     full,
   output logic     empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type entries_ff [DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = count_ff == CW'(DEPTH);
   assign empty = count_ff == '0;
   assign head_item = entries_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/bdfe_divider.sv */
module bdfe_divider
   import bdfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] num,
   input  logic [15:0] den,
   output logic        busy,
   output logic [15:0] quotient
);

   // Computes floor((2*num*32768 + den) / (2*den)) for num < den, one quotient
   // bit per cycle. The upper half of the dividend is below the divisor, so only
   // the low 16 bits produce quotient bits.
   logic        busy_ff, busy_in;
   logic [4:0]  count_ff, count_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] low_ff, low_in;
   logic [16:0] div_ff, div_in;
   logic [15:0] quo_ff, quo_in;
   logic [32:0] dividend;
   logic [17:0] trial;
   logic        take;

   assign dividend = {1'b0, num, 16'd0} + {17'd0, den};
   assign trial = {rem_ff, low_ff[15]};
   assign take = trial >= {1'b0, div_ff};
   assign busy = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      count_in = count_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = 5'd16;
         rem_in = dividend[32:16];
         low_in = dividend[15:0];
         div_in = {den, 1'b0};
         quo_in = '0;
      end else if (busy_ff) begin
         rem_in = take ? 17'(trial - {1'b0, div_ff}) : trial[16:0];
         low_in = {low_ff[14:0], 1'b0};
         quo_in = {quo_ff[14:0], take};
         count_in = count_ff - 1'b1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

endmodule

/* rtl/core/bdfe_back.sv */
module bdfe_back
   import bdfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  csr_type  csr,
   input  logic     queue_empty,
   input  item_type head_item,
   output logic     pop,
   bdfe_rsp_if.source rsp_bus
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV    = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_MUL2   = 4'd3;
   localparam logic [3:0] S_MUL3   = 4'd4;
   localparam logic [3:0] S_ACC    = 4'd5;
   localparam logic [3:0] S_EMIT_D = 4'd6;
   localparam logic [3:0] S_EMIT_P = 4'd7;
   localparam logic [3:0] S_SUM_A  = 4'd8;
   localparam logic [3:0] S_SUM_B  = 4'd9;
   localparam logic [3:0] S_EMIT_S = 4'd10;

   // Reciprocals of 20 and 24 scaled by 2^24; the estimate is at most one low.
   localparam logic [19:0] RECIP_20 = 20'd838860;
   localparam logic [19:0] RECIP_24 = 20'd699050;

   logic [3:0]  state_ff, state_in;
   item_type    item_ff, item_in;
   logic [15:0] p_ff, p_in, c_ff, c_in;
   logic [31:0] prodp_ff, prodp_in, prodf_ff, prodf_in, proddv_ff, proddv_in;
   logic [15:0] pv_ff, pv_in, f_ff, f_in, dv_ff, dv_in;
   logic [39:0] cen_prod_ff, cen_prod_in, edge_prod_ff, edge_prod_in;
   logic [15:0] cen_q_ff, cen_q_in, edge_q_ff, edge_q_in;
   logic [3:0]  sum_k_ff, sum_k_in;

   logic [15:0] top_ff [4];
   logic [15:0] top_in [4];
   logic [15:0] wmax_ff [5];
   logic [15:0] wmax_in [5];
   logic [6:0]  lvl_ff [3];
   logic [6:0]  lvl_in [3];
   logic [21:0] dsum_ff, dsum_in, psum_ff, psum_in;
   logic [19:0] csum_ff, csum_in, esum_ff, esum_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_index_ff, rsp_index_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic [6:0]  rsp_code_ff, rsp_code_in;
   logic        rsp_done_ff, rsp_done_in;

   logic        div_start, busy_p, busy_c;
   logic [15:0] q_p, q_c;
   logic [15:0] floor_q;
   logic        out_free, out_load, acc_en, acc_clear;
   logic [7:0]  out_index;
   logic [15:0] out_value;
   logic        out_done;
   logic [32:0] rnd_p, rnd_f, rnd_dv;
   logic [15:0] dv_new;
   logic [3:0]  gt;
   logic        in_center, in_edge, low_half;
   logic [19:0] cen_n, edge_n;
   logic [15:0] cen_q0, edge_q0;
   logic [20:0] cen_rem, edge_rem;
   logic [17:0] top_sum;
   logic [22:0] dsum_rnd, psum_rnd;
   logic [15:0] summary_value;
   logic [23:0] code_calc;

   bdfe_divider u_div_p (
      .clock(clock), .reset(reset), .start(div_start),
      .num(head_item.p_num), .den(head_item.p_den), .busy(busy_p), .quotient(q_p)
   );

   bdfe_divider u_div_c (
      .clock(clock), .reset(reset), .start(div_start),
      .num(head_item.c_num), .den(head_item.c_den), .busy(busy_c), .quotient(q_c)
   );

   assign floor_q = (csr.danger_floor > Q_ONE16) ? Q_ONE16 : csr.danger_floor;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign rnd_p = {1'b0, prodp_ff} + Q_HALF;
   assign rnd_f = {1'b0, prodf_ff} + Q_HALF;
   assign rnd_dv = {1'b0, proddv_ff} + Q_HALF;
   assign dv_new = rnd_dv[30:15];

   assign in_center = (item_ff.beam >= CENTER_FIRST) && (item_ff.beam < CENTER_END);
   assign in_edge = (item_ff.beam < EDGE_SPAN) || (item_ff.beam >= EDGE_START);
   assign low_half = !item_ff.beam[BEAM_W-1];

   // The top list is kept in descending order, so the compare flags are monotone.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         gt[i] = dv_new > top_ff[i];
      end
   end

   assign cen_n = csum_ff + 20'd10;
   assign edge_n = esum_ff + 20'd12;
   assign cen_q0 = cen_prod_ff[39:24];
   assign edge_q0 = edge_prod_ff[39:24];
   assign cen_rem = {1'b0, cen_n} - ({1'b0, cen_q0, 4'd0} + {3'd0, cen_q0, 2'd0});
   assign edge_rem = {1'b0, edge_n} - ({1'b0, edge_q0, 4'd0} + {2'd0, edge_q0, 3'd0});

   assign top_sum = {2'd0, top_ff[0]} + {2'd0, top_ff[1]} + {2'd0, top_ff[2]}
                  + {2'd0, top_ff[3]} + 18'd2;
   assign dsum_rnd = {1'b0, dsum_ff} + 23'd32;
   assign psum_rnd = {1'b0, psum_ff} + 23'd32;

   always_comb begin
      case (sum_k_ff)
         4'd0: summary_value = top_ff[0];
         4'd1: summary_value = top_ff[1];
         4'd2: summary_value = top_sum[17:2];
         4'd3: summary_value = dsum_rnd[21:6];
         4'd4: summary_value = wmax_ff[0];
         4'd5: summary_value = wmax_ff[1];
         4'd6: summary_value = wmax_ff[2];
         4'd7: summary_value = wmax_ff[3];
         4'd8: summary_value = wmax_ff[4];
         4'd9: summary_value = psum_rnd[21:6];
         4'd10: summary_value = {lvl_ff[0], 9'd0};
         4'd11: summary_value = {lvl_ff[1], 9'd0};
         4'd12: summary_value = {lvl_ff[2], 9'd0};
         4'd13: summary_value = cen_q_ff;
         4'd14: summary_value = edge_q_ff;
         default: summary_value = Q_ONE16;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      p_in = p_ff;
      c_in = c_ff;
      prodp_in = prodp_ff;
      prodf_in = prodf_ff;
      proddv_in = proddv_ff;
      pv_in = pv_ff;
      f_in = f_ff;
      dv_in = dv_ff;
      cen_prod_in = cen_prod_ff;
      edge_prod_in = edge_prod_ff;
      cen_q_in = cen_q_ff;
      edge_q_in = edge_q_ff;
      sum_k_in = sum_k_ff;
      pop = 1'b0;
      div_start = 1'b0;
      out_load = 1'b0;
      out_index = {2'b00, item_ff.beam};
      out_value = dv_ff;
      out_done = 1'b0;
      acc_en = 1'b0;
      acc_clear = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               div_start = 1'b1;
               item_in = head_item;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!busy_p && !busy_c) begin
               p_in = item_ff.p_zero ? 16'd0 : q_p;
               c_in = item_ff.c_zero ? 16'd0 : (item_ff.c_full ? Q_ONE16 : q_c);
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            prodp_in = p_ff * beam_gain(item_ff.beam);
            prodf_in = 16'(Q_ONE - {1'b0, floor_q}) * c_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            pv_in = rnd_p[30:15];
            f_in = floor_q + rnd_f[30:15];
            state_in = S_MUL3;
         end
         S_MUL3: begin
            proddv_in = pv_ff * f_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            dv_in = dv_new;
            acc_en = 1'b1;
            state_in = S_EMIT_D;
         end
         S_EMIT_D: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_EMIT_P;
            end
         end
         S_EMIT_P: begin
            out_index = {2'b01, item_ff.beam};
            out_value = pv_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = (item_ff.beam == LAST_BEAM) ? S_SUM_A : S_IDLE;
            end
         end
         S_SUM_A: begin
            cen_prod_in = cen_n * RECIP_20;
            edge_prod_in = edge_n * RECIP_24;
            state_in = S_SUM_B;
         end
         S_SUM_B: begin
            cen_q_in = (cen_rem >= 21'd20) ? cen_q0 + 1'b1 : cen_q0;
            edge_q_in = (edge_rem >= 21'd24) ? edge_q0 + 1'b1 : edge_q0;
            sum_k_in = '0;
            state_in = S_EMIT_S;
         end
         S_EMIT_S: begin
            out_index = SUMMARY_BASE + {4'd0, sum_k_ff};
            out_value = summary_value;
            out_done = sum_k_ff == SUMMARY_LAST;
            if (out_free) begin
               out_load = 1'b1;
               sum_k_in = sum_k_ff + 1'b1;
               if (sum_k_ff == SUMMARY_LAST) begin
                  acc_clear = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         top_in[i] = top_ff[i];
      end
      for (int i = 0; i < 5; i++) begin
         wmax_in[i] = wmax_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         lvl_in[i] = lvl_ff[i];
      end
      dsum_in = dsum_ff;
      psum_in = psum_ff;
      csum_in = csum_ff;
      esum_in = esum_ff;
      if (acc_clear) begin
         for (int i = 0; i < 4; i++) begin
            top_in[i] = '0;
         end
         for (int i = 0; i < 5; i++) begin
            wmax_in[i] = '0;
         end
         for (int i = 0; i < 3; i++) begin
            lvl_in[i] = '0;
         end
         dsum_in = '0;
         psum_in = '0;
         csum_in = '0;
         esum_in = '0;
      end else if (acc_en) begin
         dsum_in = dsum_ff + {6'd0, dv_new};
         psum_in = psum_ff + {6'd0, pv_ff};
         if (in_center) begin
            csum_in = csum_ff + {4'd0, dv_new};
            if (dv_new > wmax_ff[0]) wmax_in[0] = dv_new;
            if (pv_ff > wmax_ff[4]) wmax_in[4] = pv_ff;
         end
         if (in_edge) begin
            esum_in = esum_ff + {4'd0, dv_new};
         end
         if (low_half) begin
            if (dv_new > wmax_ff[1]) wmax_in[1] = dv_new;
         end else begin
            if (dv_new > wmax_ff[2]) wmax_in[2] = dv_new;
         end
         if (pv_ff > wmax_ff[3]) wmax_in[3] = pv_ff;
         if ({1'b0, dv_new} >= {1'b0, csr.count_level_low}) lvl_in[0] = lvl_ff[0] + 1'b1;
         if ({1'b0, dv_new} >= {1'b0, csr.count_level_mid}) lvl_in[1] = lvl_ff[1] + 1'b1;
         if ({1'b0, dv_new} >= {1'b0, csr.count_level_high}) lvl_in[2] = lvl_ff[2] + 1'b1;
         top_in[0] = gt[0] ? dv_new : top_ff[0];
         for (int i = 1; i < 4; i++) begin
            top_in[i] = gt[i-1] ? top_ff[i-1] : (gt[i] ? dv_new : top_ff[i]);
         end
      end
   end

   assign code_calc = {1'b0, out_value, 7'd0} - {8'd0, out_value} + 24'd16384;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_code_in = rsp_code_ff;
      rsp_done_in = rsp_done_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = out_index;
         rsp_value_in = out_value;
         rsp_code_in = code_calc[21:15];
         rsp_done_in = out_done;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.feature_index = rsp_index_ff;
   assign rsp_bus.feature_value = rsp_value_ff;
   assign rsp_bus.feature_code = rsp_code_ff;
   assign rsp_bus.frame_done = rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            top_ff[i] <= '0;
         end
         for (int i = 0; i < 5; i++) begin
            wmax_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            lvl_ff[i] <= '0;
         end
         dsum_ff <= '0;
         psum_ff <= '0;
         csum_ff <= '0;
         esum_ff <= '0;
         sum_k_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            top_ff[i] <= top_in[i];
         end
         for (int i = 0; i < 5; i++) begin
            wmax_ff[i] <= wmax_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            lvl_ff[i] <= lvl_in[i];
         end
         dsum_ff <= dsum_in;
         psum_ff <= psum_in;
         csum_ff <= csum_in;
         esum_ff <= esum_in;
         sum_k_ff <= sum_k_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      p_ff <= p_in;
      c_ff <= c_in;
      prodp_ff <= prodp_in;
      prodf_ff <= prodf_in;
      proddv_ff <= proddv_in;
      pv_ff <= pv_in;
      f_ff <= f_in;
      dv_ff <= dv_in;
      cen_prod_ff <= cen_prod_in;
      edge_prod_ff <= edge_prod_in;
      cen_q_ff <= cen_q_in;
      edge_q_ff <= edge_q_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_code_ff <= rsp_code_in;
      rsp_done_ff <= rsp_done_in;
   end

`ifndef SYNTH
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!busy_p && !busy_c))
      else $error("divider still busy while waiting for a word");

   a_top_sorted: assert property (@(posedge clock) disable iff (reset)
      (top_ff[0] >= top_ff[1]) && (top_ff[1] >= top_ff[2]) && (top_ff[2] >= top_ff[3]))
      else $error("top danger list out of order");

   a_danger_le_prox: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_D) |-> (dv_ff <= pv_ff))
      else $error("danger exceeds proximity");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_done) |=> (state_ff == S_IDLE && dsum_ff == '0))
      else $error("frame accumulators not cleared after last summary");
`endif

endmodule
